/* hdl/ffck_pkg.sv */
// shared constants and types for the calculator key-entry block
package ffck_pkg;

    localparam int VALUE_WIDTH_DEF   = 64;
    localparam int FRACTION_BITS_DEF = 16;

    typedef enum logic [1:0] {
        CMD_DIGIT  = 2'd0,
        CMD_CYCLE  = 2'd1,
        CMD_EQUALS = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_OPER   = 2'd1,
        PH_SECOND = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_NONE = 3'd4;

    typedef enum logic [1:0] {
        AOP_ADD = 2'd0,
        AOP_SUB = 2'd1,
        AOP_MUL = 2'd2,
        AOP_DIV = 2'd3
    } aop_t;

endpackage

/* hdl/ffck_alu.sv */
// bit-serial arithmetic unit: saturating add, subtract, multiply and divide
module ffck_alu
    import ffck_pkg::*;
#(
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  aop_t                   op,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    input  logic [5:0]             shift,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] res,
    output logic                   err
);
    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(2 * W + 1) + 1;
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [2:0] {S_IDLE, S_ADD, S_MUL, S_DIV, S_FIX, S_DONE} st_t;

    st_t            st_reg;
    aop_t           op_reg;
    logic [W-1:0]   a_reg, b_reg, res_reg;
    logic           neg_reg, err_reg, carry_reg;
    logic [CW-1:0]  cnt_reg;
    logic [2*W-1:0] acc_reg;    // product, or dividend shifting into quotient
    logic [W:0]     rem_reg;
    logic [5:0]     sh_reg;

    logic [W-1:0] ma, mb;
    assign ma = a[W-1] ? (~a + 1'b1) : a;
    assign mb = b[W-1] ? (~b + 1'b1) : b;

    // serial add bit
    logic bb, sbit, cnext;
    assign bb    = (op_reg == AOP_SUB) ? ~b_reg[0] : b_reg[0];
    assign sbit  = a_reg[0] ^ bb ^ carry_reg;
    assign cnext = (a_reg[0] & bb) | (a_reg[0] & carry_reg) | (bb & carry_reg);

    // divide step
    logic [W:0] rsh, rdiff;
    assign rsh   = {rem_reg[W-1:0], acc_reg[2*W-1]};
    assign rdiff = rsh - {1'b0, b_reg};

    // magnitude shifted down, with overflow check on the high part
    logic [2*W-1:0] pshift;
    logic [W-1:0]   mag;
    logic           ovf;
    assign pshift = acc_reg >> sh_reg;
    always_comb begin
        mag = pshift[W-1:0];
        ovf = |pshift[2*W-1:W];
        if (op_reg == AOP_DIV) begin
            mag = acc_reg[W-1:0];
            ovf = |acc_reg[2*W-1:W];
        end
        if (neg_reg) begin
            ovf = ovf | (mag > VMIN);
        end else begin
            ovf = ovf | mag[W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
        end else begin
            case (st_reg)
                S_IDLE: begin
                    if (start) begin
                        op_reg    <= op;
                        err_reg   <= 1'b0;
                        carry_reg <= (op == AOP_SUB);
                        cnt_reg   <= '0;
                        sh_reg    <= shift;
                        neg_reg   <= a[W-1] ^ b[W-1];
                        rem_reg   <= '0;
                        case (op)
                            AOP_ADD, AOP_SUB: begin
                                a_reg  <= a;
                                b_reg  <= b;
                                st_reg <= S_ADD;
                            end
                            AOP_MUL: begin
                                a_reg   <= ma;
                                b_reg   <= mb;
                                acc_reg <= '0;
                                st_reg  <= S_MUL;
                            end
                            default: begin
                                b_reg   <= mb;
                                acc_reg <= {{W{1'b0}}, ma} << FRACTION_BITS;
                                if (b == '0) begin
                                    err_reg <= 1'b1;
                                    res_reg <= a[W-1] ? VMIN : VMAX;
                                    st_reg  <= S_DONE;
                                end else begin
                                    st_reg <= S_DIV;
                                end
                            end
                        endcase
                    end
                end
                S_ADD: begin
                    // result bits enter at the top of res_reg
                    res_reg   <= {sbit, res_reg[W-1:1]};
                    a_reg     <= {1'b0, a_reg[W-1:1]};
                    b_reg     <= {b_reg[0], b_reg[W-1:1]};
                    carry_reg <= cnext;
                    if (cnt_reg == CW'(W - 1)) begin
                        // signed overflow: sign of operands equal, sign of sum differs
                        if ((a_reg[0] == bb) && (sbit != a_reg[0])) begin
                            err_reg <= 1'b1;
                            res_reg <= a_reg[0] ? VMIN : VMAX;
                        end
                        st_reg <= S_DONE;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_MUL: begin
                    // shift-add from the top multiplier bit
                    if (b_reg[W-1]) begin
                        acc_reg <= (acc_reg << 1) + {{W{1'b0}}, a_reg};
                    end else begin
                        acc_reg <= acc_reg << 1;
                    end
                    b_reg <= b_reg << 1;
                    if (cnt_reg == CW'(W - 1)) st_reg <= S_FIX;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_DIV: begin
                    acc_reg <= {acc_reg[2*W-2:0], ~rdiff[W]};
                    rem_reg <= rdiff[W] ? rsh : rdiff;
                    if (cnt_reg == CW'(2 * W - 1)) st_reg <= S_FIX;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_FIX: begin
                    if (ovf) begin
                        err_reg <= 1'b1;
                        res_reg <= neg_reg ? VMIN : VMAX;
                    end else begin
                        res_reg <= neg_reg ? (~mag + 1'b1) : mag;
                    end
                    st_reg <= S_DONE;
                end
                S_DONE: st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign done = (st_reg == S_DONE);
    assign res  = res_reg;
    assign err  = err_reg;
endmodule

/* hdl/four_function_calculator_keys_top.sv */
// top level of the calculator key-entry block
// usage: one key per input beat (s_cmd, s_digit), one display beat per key on m_.
// a digit key appends (value*10 + digit), cycle operator folds a pending calculation
// and steps the operator, equals computes; values are signed fixed point.
// from key acceptance, a plain key or a fresh digit goes straight to the result beat;
// a calculation waits on the bit-serial unit, and a digit append runs multiply by
// ten then add. one key at a time: s_ready is high only while idle, from the cycle
// after the result beat is taken.
// the result sits in an output register until m_ready takes it; a stalled receiver
// holds the block in the output state with the beat unchanged.
// reset (aresetn low, synchronous) returns to first-operand entry with both
// operands zero and no operator pending.
module four_function_calculator_keys_top
    import ffck_pkg::*;
#(
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [3:0]  s_digit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_shows_operator,
    output logic signed [63:0] m_shown_value,
    output logic [1:0]  m_shown_operator,
    output logic        m_arith_error
);
    localparam int W = VALUE_WIDTH;
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};

    typedef enum logic [2:0] {T_IDLE, T_DEC, T_WAIT, T_ADDD, T_WAIT2, T_OUT} tst_t;

    tst_t         st_reg;
    phase_t       ph_reg;
    logic [2:0]   op_reg;
    logic [W-1:0] first_reg, second_reg, dval_reg, tmp_reg;
    logic [1:0]   cmd_reg;
    logic         dsat_reg;
    logic         tgt_second_reg, err_acc_reg;
    logic         showop_reg, err_out_reg;
    logic [W-1:0] shown_reg;
    logic [1:0]   sop_reg;

    logic         alu_start;
    aop_t         alu_op;
    logic [W-1:0] alu_a, alu_b;
    logic [5:0]   alu_sh;
    logic         alu_done, alu_err;
    logic [W-1:0] alu_res;

    // digit << FRACTION_BITS, saturated
    logic [W+35:0] dwide;
    logic          dsat;
    logic [W-1:0]  dval;
    assign dwide = {{(W+32){1'b0}}, s_digit} << FRACTION_BITS;
    assign dsat  = |dwide[W+35:W-1];
    assign dval  = dsat ? VMAX : dwide[W-1:0];

    ffck_alu #(.VALUE_WIDTH(W), .FRACTION_BITS(FRACTION_BITS)) u_alu (
        .aclk(aclk), .aresetn(aresetn), .start(alu_start), .op(alu_op),
        .a(alu_a), .b(alu_b), .shift(alu_sh), .done(alu_done),
        .res(alu_res), .err(alu_err)
    );

    logic [2:0] next_op;
    always_comb begin
        case (ph_reg == PH_OPER ? op_reg : OP_NONE)
            OP_ADD:  next_op = OP_SUB;
            OP_SUB:  next_op = OP_MUL;
            OP_MUL:  next_op = OP_DIV;
            OP_DIV:  next_op = OP_ADD;
            OP_NONE: next_op = OP_ADD;
            default: next_op = OP_DIV;
        endcase
    end

    // unit requests: T_DEC starts a calc or the times-ten, T_ADDD adds the digit
    always_comb begin
        alu_start = 1'b0;
        alu_op    = AOP_ADD;
        alu_a     = first_reg;
        alu_b     = second_reg;
        alu_sh    = 6'(FRACTION_BITS);
        if (st_reg == T_DEC) begin
            if (cmd_reg == CMD_DIGIT) begin
                alu_start = 1'b1;
                alu_op    = AOP_MUL;
                alu_a     = tgt_second_reg ? second_reg : first_reg;
                alu_b     = W'(10);
                alu_sh    = 6'd0;
            end else begin
                alu_start = op_reg[2] == 1'b0;
                alu_op    = aop_t'(op_reg[1:0]);
            end
        end else if (st_reg == T_ADDD) begin
            alu_start = 1'b1;
            alu_op    = AOP_ADD;
            alu_a     = tmp_reg;
            alu_b     = dval_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= T_IDLE;
            ph_reg     <= PH_FIRST;
            op_reg     <= OP_NONE;
            first_reg  <= '0;
            second_reg <= '0;
        end else begin
            case (st_reg)
                T_IDLE: begin
                    if (s_valid) begin
                        cmd_reg     <= s_cmd;
                        dsat_reg    <= dsat;
                        dval_reg    <= dval;
                        err_acc_reg <= 1'b0;
                        showop_reg  <= 1'b0;
                        sop_reg     <= 2'd0;
                        err_out_reg <= 1'b0;
                        case (cmd_t'(s_cmd))
                            CMD_DIGIT: begin
                                case (ph_reg)
                                    PH_FIRST: begin
                                        tgt_second_reg <= 1'b0;
                                        st_reg <= T_DEC;
                                    end
                                    PH_SECOND: begin
                                        tgt_second_reg <= 1'b1;
                                        st_reg <= T_DEC;
                                    end
                                    PH_OPER: begin
                                        second_reg  <= dval;
                                        shown_reg   <= dval;
                                        err_out_reg <= dsat;
                                        ph_reg      <= PH_SECOND;
                                        st_reg      <= T_OUT;
                                    end
                                    default: begin
                                        first_reg   <= dval;
                                        shown_reg   <= dval;
                                        err_out_reg <= dsat;
                                        ph_reg      <= PH_FIRST;
                                        op_reg      <= OP_NONE;
                                        st_reg      <= T_OUT;
                                    end
                                endcase
                            end
                            CMD_CYCLE: begin
                                if (ph_reg == PH_SECOND) begin
                                    st_reg <= T_DEC;
                                end else begin
                                    op_reg     <= next_op;
                                    ph_reg     <= PH_OPER;
                                    showop_reg <= 1'b1;
                                    sop_reg    <= next_op[1:0];
                                    shown_reg  <= '0;
                                    st_reg     <= T_OUT;
                                end
                            end
                            CMD_EQUALS: begin
                                if (ph_reg == PH_SECOND || ph_reg == PH_DONE) begin
                                    st_reg <= T_DEC;
                                end else begin
                                    shown_reg <= first_reg;
                                    ph_reg    <= PH_DONE;
                                    st_reg    <= T_OUT;
                                end
                            end
                            default: begin
                                showop_reg <= (ph_reg == PH_OPER);
                                sop_reg    <= (ph_reg == PH_OPER) ? op_reg[1:0] : 2'd0;
                                shown_reg  <= (ph_reg == PH_OPER) ? '0 :
                                              (ph_reg == PH_SECOND) ? second_reg : first_reg;
                                st_reg     <= T_OUT;
                            end
                        endcase
                    end
                end
                T_DEC: begin
                    if (alu_start) begin
                        st_reg <= T_WAIT;
                    end else begin
                        // no operator pending: calc leaves the first operand
                        tmp_reg <= first_reg;
                        st_reg  <= T_WAIT2;
                    end
                end
                T_WAIT: begin
                    if (alu_done) begin
                        tmp_reg     <= alu_res;
                        err_acc_reg <= alu_err;
                        st_reg      <= (cmd_reg == CMD_DIGIT) ? T_ADDD : T_WAIT2;
                    end
                end
                T_ADDD: st_reg <= T_WAIT2;
                T_WAIT2: begin
                    if (cmd_reg == CMD_DIGIT) begin
                        if (alu_done) begin
                            if (tgt_second_reg) second_reg <= alu_res;
                            else first_reg <= alu_res;
                            shown_reg   <= alu_res;
                            err_out_reg <= err_acc_reg | alu_err | dsat_reg;
                            st_reg      <= T_OUT;
                        end
                    end else begin
                        first_reg   <= tmp_reg;
                        err_out_reg <= err_acc_reg;
                        if (cmd_reg == CMD_CYCLE) begin
                            op_reg     <= next_op;
                            ph_reg     <= PH_OPER;
                            showop_reg <= 1'b1;
                            sop_reg    <= next_op[1:0];
                            shown_reg  <= '0;
                        end else begin
                            shown_reg <= tmp_reg;
                            ph_reg    <= PH_DONE;
                        end
                        st_reg <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (m_ready) st_reg <= T_IDLE;
                end
                default: st_reg <= T_IDLE;
            endcase
        end
    end

    assign s_ready          = (st_reg == T_IDLE);
    assign m_valid          = (st_reg == T_OUT);
    assign m_shows_operator = showop_reg;
    assign m_shown_value    = 64'(signed'(shown_reg));
    assign m_shown_operator = sop_reg;
    assign m_arith_error    = err_out_reg;
endmodule

/* bench/testbench.sv */
// self-checking bench for the calculator key-entry block
`timescale 1ns / 100ps

module testbench;
    import ffck_pkg::*;

    localparam longint VMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint VMIN = -VMAX - 1;
    localparam int FB = 16;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] digit;
    } key_t;

    typedef struct packed {
        logic        shows_op;
        logic [63:0] value;
        logic [1:0]  op;
        logic        err;
    } display_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [1:0] s_cmd = '0;
    logic [3:0] s_digit = '0;
    logic m_valid;
    logic m_ready = 0;
    logic m_shows_operator;
    logic signed [63:0] m_shown_value;
    logic [1:0] m_shown_operator;
    logic m_arith_error;

    four_function_calculator_keys_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_digit(s_digit),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_shows_operator(m_shows_operator), .m_shown_value(m_shown_value),
        .m_shown_operator(m_shown_operator), .m_arith_error(m_arith_error)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    key_t     key_queue[$];
    display_t display_queue[$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_off = 0;
    int       mismatches = 0;
    int       quiet_cycles = 0;
    bit       running = 0;

    // predictor state
    phase_t     calc_phase;
    logic [2:0] calc_op;
    longint     acc_first, acc_second;

    function automatic longint from_magnitude(bit neg, logic [63:0] m, ref bit err);
        if (neg) begin
            if (m > 64'h8000_0000_0000_0000) begin
                err = 1;
                return VMIN;
            end
            return -$signed(m);
        end
        if (m > 64'h7FFF_FFFF_FFFF_FFFF) begin
            err = 1;
            return VMAX;
        end
        return $signed(m);
    endfunction

    function automatic logic [63:0] magnitude(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint sat_add(longint a, longint b, ref bit err);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(VMAX)) begin
            err = 1;
            return VMAX;
        end
        if (s < 65'(VMIN)) begin
            err = 1;
            return VMIN;
        end
        return longint'(s);
    endfunction

    function automatic longint sat_sub(longint a, longint b, ref bit err);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s > 65'(VMAX)) begin
            err = 1;
            return VMAX;
        end
        if (s < 65'(VMIN)) begin
            err = 1;
            return VMIN;
        end
        return longint'(s);
    endfunction

    function automatic longint fixed_mul(longint a, longint b, int sh, ref bit err);
        logic [127:0] p, q;
        p = 128'(magnitude(a)) * 128'(magnitude(b));
        q = p >> sh;
        return from_magnitude((a < 0) != (b < 0),
                              q[127:64] != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0], err);
    endfunction

    function automatic longint fixed_div(longint a, longint b, ref bit err);
        logic [127:0] q;
        if (b == 0) begin
            err = 1;
            return a < 0 ? VMIN : VMAX;
        end
        q = (128'(magnitude(a)) << FB) / 128'(magnitude(b));
        return from_magnitude((a < 0) != (b < 0),
                              q[127:64] != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0], err);
    endfunction

    function automatic longint evaluate(ref bit err);
        case (calc_op)
            OP_ADD: return sat_add(acc_first, acc_second, err);
            OP_SUB: return sat_sub(acc_first, acc_second, err);
            OP_MUL: return fixed_mul(acc_first, acc_second, FB, err);
            OP_DIV: return fixed_div(acc_first, acc_second, err);
            default: return acc_first;
        endcase
    endfunction

    function automatic longint digit_fixed(logic [3:0] d, ref bit err);
        return from_magnitude(0, 64'(d) << FB, err);
    endfunction

    function automatic longint append_digit(longint v, logic [3:0] d, ref bit err);
        longint t;
        t = fixed_mul(v, 10, 0, err);
        return sat_add(t, digit_fixed(d, err), err);
    endfunction

    function automatic display_t press_key(key_t k);
        display_t r;
        bit err;
        bit showop;
        longint shown;
        err = 0;
        showop = 0;
        shown = 0;
        case (cmd_t'(k.cmd))
            CMD_DIGIT: begin
                case (calc_phase)
                    PH_FIRST: begin
                        acc_first = append_digit(acc_first, k.digit, err);
                        shown = acc_first;
                    end
                    PH_SECOND: begin
                        acc_second = append_digit(acc_second, k.digit, err);
                        shown = acc_second;
                    end
                    PH_OPER: begin
                        acc_second = digit_fixed(k.digit, err);
                        shown = acc_second;
                        calc_phase = PH_SECOND;
                    end
                    default: begin
                        acc_first = digit_fixed(k.digit, err);
                        shown = acc_first;
                        calc_phase = PH_FIRST;
                        calc_op = OP_NONE;
                    end
                endcase
            end
            CMD_CYCLE: begin
                if (calc_phase == PH_SECOND) acc_first = evaluate(err);
                if (calc_phase != PH_OPER) calc_op = OP_NONE;
                case (calc_op)
                    OP_ADD: calc_op = OP_SUB;
                    OP_SUB: calc_op = OP_MUL;
                    OP_MUL: calc_op = OP_DIV;
                    OP_DIV: calc_op = OP_ADD;
                    OP_NONE: calc_op = OP_ADD;
                    default: calc_op = OP_DIV;
                endcase
                calc_phase = PH_OPER;
                showop = 1;
            end
            CMD_EQUALS: begin
                if (calc_phase == PH_SECOND || calc_phase == PH_DONE)
                    acc_first = evaluate(err);
                shown = acc_first;
                calc_phase = PH_DONE;
            end
            default: begin
                if (calc_phase == PH_OPER) showop = 1;
                else if (calc_phase == PH_SECOND) shown = acc_second;
                else shown = acc_first;
            end
        endcase
        r.shows_op = showop;
        r.value = showop ? 64'd0 : 64'(shown);
        r.op = showop ? calc_op[1:0] : 2'd0;
        r.err = err;
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                display_queue.push_back(press_key(key_t'({s_cmd, s_digit})));
            end
            if (!s_valid || s_ready) begin
                if (key_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    key_t k;
                    k = key_queue.pop_front();
                    s_valid <= 1;
                    s_cmd <= k.cmd;
                    s_digit <= k.digit;
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // receiver stalls and long hold-off
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            display_t got, want;
            got = {m_shows_operator, m_shown_value, m_shown_operator, m_arith_error};
            if (display_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: %h", got);
            end else begin
                want = display_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp op=%b val=%h sym=%0d err=%b",
                                 want.shows_op, want.value, want.op, want.err,
                                 " got op=%b val=%h sym=%0d err=%b",
                                 got.shows_op, got.value, got.op, got.err);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !running) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_key(logic [1:0] c, logic [3:0] d);
        key_t k;
        k.cmd = c;
        k.digit = d;
        key_queue.push_back(k);
    endtask

    task automatic drain();
        while (key_queue.size() > 0 || s_valid || display_queue.size() > 0) @(posedge aclk);
    endtask

    // mostly well-formed sums with random digits, some noise
    task automatic random_keys(int n);
        repeat (n) begin
            int r;
            r = $urandom_range(99);
            if (r < 55) add_key(CMD_DIGIT, $urandom_range(r < 3 ? 15 : 9));
            else if (r < 75) add_key(CMD_CYCLE, $urandom_range(15));
            else if (r < 95) add_key(CMD_EQUALS, $urandom_range(15));
            else add_key(CMD_NOP, $urandom_range(15));
        end
    endtask

    initial begin
        calc_phase = PH_FIRST;
        calc_op = OP_NONE;
        acc_first = 0;
        acc_second = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        running = 1;

        // directed: extremes, every operator, div by zero, overflow, nop, wide digit
        add_key(CMD_NOP, 0);
        add_key(CMD_EQUALS, 0);
        add_key(CMD_DIGIT, 9);
        add_key(CMD_CYCLE, 0);
        add_key(CMD_CYCLE, 0);
        add_key(CMD_NOP, 0);
        add_key(CMD_CYCLE, 0);
        add_key(CMD_CYCLE, 0);
        add_key(CMD_DIGIT, 0);
        add_key(CMD_NOP, 15);
        add_key(CMD_EQUALS, 0);
        add_key(CMD_EQUALS, 0);
        add_key(CMD_DIGIT, 15);
        add_key(CMD_CYCLE, 0);
        add_key(CMD_CYCLE, 0);
        add_key(CMD_DIGIT, 7);
        add_key(CMD_EQUALS, 0);
        add_key(CMD_EQUALS, 0);
        repeat (7) add_key(CMD_EQUALS, 0);
        drain();

        // long digit string saturates; then negative via subtract
        repeat (20) add_key(CMD_DIGIT, 9);
        add_key(CMD_CYCLE, 0);
        add_key(CMD_DIGIT, 9);
        add_key(CMD_EQUALS, 0);
        add_key(CMD_DIGIT, 0);
        add_key(CMD_CYCLE, 0);
        add_key(CMD_CYCLE, 0);
        repeat (20) add_key(CMD_DIGIT, 9);
        add_key(CMD_EQUALS, 0);
        add_key(CMD_CYCLE, 0);
        add_key(CMD_CYCLE, 0);
        add_key(CMD_CYCLE, 0);
        add_key(CMD_DIGIT, 0);
        add_key(CMD_EQUALS, 0);
        drain();

        // sender waits here until all beats are back
        random_keys(450);
        drain();
        send_idle_pct = 65;
        random_keys(450);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 65;
        random_keys(450);
        drain();
        send_idle_pct = 11;
        recv_stall_pct = 11;
        hold_off = 3000;
        random_keys(500);
        drain();
        repeat (300) @(posedge aclk);

        if (mismatches == 0 && display_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
